// ----- hw/rtl/radial_distortion_newton_inverse_defines.svh -----
// shared assertion macros for the radial distortion block
`ifndef RADIAL_DISTORTION_NEWTON_INVERSE_DEFINES_SVH
`define RADIAL_DISTORTION_NEWTON_INVERSE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RDNI_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RDNI_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- hw/rtl/rdni_pkg.sv -----
`timescale 1ns / 1ps
package rdni_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_K1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_SINGULAR = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    localparam logic [7:0] LIMIT_RESET = 8'd100;

    // operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB,
        ALU_DIV,
        ALU_CLAMP
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } alu_sts_t;
endpackage

// ----- hw/rtl/rdni_alu.sv -----
`timescale 1ns / 1ps
// multi-cycle saturating q-format unit: multiply, add, sub, divide, clamp
module rdni_alu #(
    parameter int COORD_WIDTH = rdni_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rdni_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rdni_pkg::alu_ctl_t     ctl,
    input  logic signed [63:0]     a,
    input  logic signed [63:0]     b,
    output rdni_pkg::alu_sts_t     sts,
    output logic signed [63:0]     y
);
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] CW_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] CW_LO = -CW_HI - 64'sd1;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MFIN, S_DIV, S_DFIN, S_DONE} st_t;

    st_t          st_reg;
    logic         neg_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] acc_reg;
    logic [1:0]   part_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  rem_reg, quo_reg, lo_reg;
    logic [63:0]  y_reg;
    logic         sat_reg;

    logic [63:0] mag_a, mag_b;
    logic [31:0] pa, pb;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    logic [127:0] rounded;
    logic [64:0] rsh;
    logic signed [64:0] sum_w;
    logic [64:0] rem_sh;

    always_comb
    begin
        mag_a = a[63] ? (64'd0 - a) : a;
        mag_b = b[63] ? (64'd0 - b) : b;
        pa    = part_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb    = part_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp    = 64'(pa) * 64'(pb);
        pp_sh = 128'(pp) << (7'(part_reg[0]) * 7'd32 + 7'(part_reg[1]) * 7'd32);
        rounded = acc_reg + (128'd1 << (FRAC_BITS - 1));
        rsh   = 65'(rounded >> FRAC_BITS);
        sum_w = (ctl.op == rdni_pkg::ALU_SUB) ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
        rem_sh = {rem_reg, lo_reg[63]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            sat_reg  <= 1'b0;
            part_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    sat_reg <= 1'b0;
                    if (ctl.start)
                    begin
                        neg_reg <= a[63] ^ b[63];
                        ma_reg  <= mag_a;
                        mb_reg  <= mag_b;
                        case (ctl.op)
                            rdni_pkg::ALU_MUL:
                            begin
                                acc_reg  <= '0;
                                part_reg <= '0;
                                st_reg   <= S_MUL;
                            end
                            rdni_pkg::ALU_ADD, rdni_pkg::ALU_SUB:
                            begin
                                if (sum_w[64] != sum_w[63])
                                begin
                                    sat_reg <= 1'b1;
                                    y_reg   <= sum_w[64] ? NEG_MAX : POS_MAX;
                                end
                                else
                                    y_reg <= sum_w[63:0];
                                st_reg <= S_DONE;
                            end
                            rdni_pkg::ALU_DIV:
                            begin
                                rem_reg <= mag_a >> (64 - FRAC_BITS);
                                lo_reg  <= mag_a << FRAC_BITS;
                                quo_reg <= '0;
                                cnt_reg <= '0;
                                st_reg  <= S_DIV;
                            end
                            rdni_pkg::ALU_CLAMP:
                            begin
                                if (a > CW_HI)
                                begin
                                    sat_reg <= 1'b1;
                                    y_reg   <= CW_HI;
                                end
                                else if (a < CW_LO)
                                begin
                                    sat_reg <= 1'b1;
                                    y_reg   <= CW_LO;
                                end
                                else
                                    y_reg <= a;
                                st_reg <= S_DONE;
                            end
                            default: st_reg <= S_DONE;
                        endcase
                    end
                end
                S_MUL:
                begin
                    acc_reg  <= acc_reg + pp_sh;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd3)
                        st_reg <= S_MFIN;
                end
                S_MFIN:
                begin
                    // magnitude must fit; negative side allows 2^63
                    if (rsh[64] || (rounded[127:FRAC_BITS+64] != '0)
                        || (!neg_reg && rsh[63]) || (neg_reg && rsh[63] && rsh[62:0] != '0))
                    begin
                        sat_reg <= 1'b1;
                        y_reg   <= neg_reg ? NEG_MAX : POS_MAX;
                    end
                    else
                        y_reg <= neg_reg ? (64'd0 - rsh[63:0]) : rsh[63:0];
                    st_reg <= S_DONE;
                end
                S_DIV:
                begin
                    if (cnt_reg == 7'd0 && rem_reg >= mb_reg)
                    begin
                        sat_reg <= 1'b1;
                        y_reg   <= neg_reg ? NEG_MAX : POS_MAX;
                        st_reg  <= S_DONE;
                    end
                    else
                    begin
                        lo_reg <= lo_reg << 1;
                        if (rem_sh >= 65'(mb_reg))
                        begin
                            rem_reg <= 64'(rem_sh - 65'(mb_reg));
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd63)
                            st_reg <= S_DFIN;
                    end
                end
                S_DFIN:
                begin
                    if (!neg_reg && quo_reg[63])
                    begin
                        sat_reg <= 1'b1;
                        y_reg   <= POS_MAX;
                    end
                    else if (neg_reg && quo_reg[63] && quo_reg[62:0] != '0)
                    begin
                        sat_reg <= 1'b1;
                        y_reg   <= NEG_MAX;
                    end
                    else
                        y_reg <= neg_reg ? (64'd0 - quo_reg) : quo_reg;
                    st_reg <= S_DONE;
                end
                S_DONE:
                    st_reg <= S_IDLE;
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign sts.done = (st_reg == S_DONE);
    assign sts.sat  = sat_reg;
    assign y        = y_reg;
endmodule

// ----- hw/rtl/radial_distortion_newton_inverse.sv -----
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------
// command   | start / busy               | op, in_x, in_y
// result    | done strobe (one cycle)    | out_x, out_y, jac_*, update_count, status
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one shared saturating unit runs every product, sum, quotient and clamp in turn
// a product sums partial products of the 32-bit halves, a quotient is bitwise long division
// when the radius is zero, eval skips the derivative steps and uses an identity jacobian
// busy stays high from the accepted command to the end of the result strobe
// reset clears the sequencer, flags, count and k/tol config (limit resets to 100);
// working registers and status are not reset; the receiver cannot stall the result
module radial_distortion_newton_inverse #(
    parameter int COORD_WIDTH = rdni_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rdni_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [COORD_WIDTH-1:0]       in_x,
    input  logic signed [COORD_WIDTH-1:0]       in_y,
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       out_x,
    output logic signed [COORD_WIDTH-1:0]       out_y,
    output logic signed [COORD_WIDTH-1:0]       jac_xx,
    output logic signed [COORD_WIDTH-1:0]       jac_xy,
    output logic signed [COORD_WIDTH-1:0]       jac_yx,
    output logic signed [COORD_WIDTH-1:0]       jac_yy,
    output logic [8:0]                          update_count,
    output logic [1:0]                          status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdni_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdni_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // register file of the sequencer
    typedef enum logic [4:0] {
        R_X, R_Y, R_PX, R_PY, R_R2, R_R4, R_R6, R_C, R_D, R_T, R_U,
        R_FX, R_FY, R_J0, R_J1, R_J2, R_J3, R_DX, R_DY, R_DET, R_NX, R_NY,
        R_K1, R_K2, R_K3, R_ONE, R_XD, R_YD
    } rsel_t;

    // micro-operations; eval is a shared subroutine
    typedef enum logic [6:0] {
        P_IDLE,
        E_XX, E_YY, E_R2, E_R4, E_R6, E_K1R2, E_C1, E_K2R4, E_K3R6, E_C2, E_C,
        E_FX, E_FY, E_ZCHK, E_D1, E_D2, E_KR2, E_D3, E_D4, E_D5, E_D6,
        E_KR4, E_D7, E_D8, E_D9, E_D10, E_D11, E_D12,
        E_XD, E_YD, E_J0M, E_J0, E_J1, E_J2, E_J3M, E_J3, E_RET,
        N_DX, N_DY, N_CONV, N_A, N_B, N_DET, N_DCHK, N_C, N_D, N_NX,
        N_E, N_F, N_NY, N_QX, N_SX, N_CX, N_QY, N_SY, N_CY, N_CNT,
        F_C0, F_C1, F_C2, F_C3, F_CX, F_CY, P_OUT
    } step_t;

    typedef struct packed {
        rdni_pkg::alu_op_t op;
        rsel_t a;
        rsel_t b;
        rsel_t dst;
    } uop_t;

    step_t step_reg;
    logic  inv_reg;
    logic  issued_reg;
    logic  sat_acc_reg;
    logic  singular_reg;
    logic  limited_reg;
    logic [8:0] count_reg;
    logic signed [63:0] rf_reg [0:27];
    logic signed [31:0] k1_reg, k2_reg, k3_reg;
    logic [15:0] tol_reg;
    logic [7:0]  limit_reg;
    logic        done_reg;
    logic [1:0]  status_reg;

    rdni_pkg::alu_ctl_t alu_ctl;
    rdni_pkg::alu_sts_t alu_sts;
    logic signed [63:0] alu_a, alu_b, alu_y;
    uop_t  uop;
    logic  is_alu;
    logic  conv;
    logic [63:0] adx, ady;
    logic [32:0] norm;

    rdni_alu #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .a     (alu_a),
        .b     (alu_b),
        .sts   (alu_sts),
        .y     (alu_y)
    );

    // microcode: what each arithmetic step does
    always_comb
    begin
        is_alu = 1'b1;
        uop    = '{rdni_pkg::ALU_ADD, R_X, R_X, R_T};
        case (step_reg)
            E_XX:   uop = '{rdni_pkg::ALU_MUL, R_X,  R_X,  R_T};
            E_YY:   uop = '{rdni_pkg::ALU_MUL, R_Y,  R_Y,  R_U};
            E_R2:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_R2};
            E_R4:   uop = '{rdni_pkg::ALU_MUL, R_R2, R_R2, R_R4};
            E_R6:   uop = '{rdni_pkg::ALU_MUL, R_R4, R_R2, R_R6};
            E_K1R2: uop = '{rdni_pkg::ALU_MUL, R_K1, R_R2, R_T};
            E_C1:   uop = '{rdni_pkg::ALU_ADD, R_ONE, R_T, R_C};
            E_K2R4: uop = '{rdni_pkg::ALU_MUL, R_K2, R_R4, R_T};
            E_K3R6: uop = '{rdni_pkg::ALU_MUL, R_K3, R_R6, R_U};
            E_C2:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_C:    uop = '{rdni_pkg::ALU_ADD, R_C,  R_T,  R_C};
            E_FX:   uop = '{rdni_pkg::ALU_MUL, R_X,  R_C,  R_FX};
            E_FY:   uop = '{rdni_pkg::ALU_MUL, R_Y,  R_C,  R_FY};
            // d = k1+k1 + 4 (k2 r2) + 6 (k3 r4), each a chain of saturating adds
            E_D1:   uop = '{rdni_pkg::ALU_ADD, R_K1, R_K1, R_D};
            E_KR2:  uop = '{rdni_pkg::ALU_MUL, R_K2, R_R2, R_U};
            E_D2:   uop = '{rdni_pkg::ALU_ADD, R_U,  R_U,  R_T};
            E_D3:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D4:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D5:   uop = '{rdni_pkg::ALU_ADD, R_D,  R_T,  R_D};
            E_KR4:  uop = '{rdni_pkg::ALU_MUL, R_K3, R_R4, R_U};
            E_D6:   uop = '{rdni_pkg::ALU_ADD, R_U,  R_U,  R_T};
            E_D7:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D8:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D9:   uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D10:  uop = '{rdni_pkg::ALU_ADD, R_T,  R_U,  R_T};
            E_D11:  uop = '{rdni_pkg::ALU_ADD, R_D,  R_T,  R_D};
            E_XD:   uop = '{rdni_pkg::ALU_MUL, R_X,  R_D,  R_XD};
            E_YD:   uop = '{rdni_pkg::ALU_MUL, R_Y,  R_D,  R_YD};
            E_J0M:  uop = '{rdni_pkg::ALU_MUL, R_XD, R_X,  R_T};
            E_J0:   uop = '{rdni_pkg::ALU_ADD, R_C,  R_T,  R_J0};
            E_J1:   uop = '{rdni_pkg::ALU_MUL, R_XD, R_Y,  R_J1};
            E_J2:   uop = '{rdni_pkg::ALU_MUL, R_YD, R_X,  R_J2};
            E_J3M:  uop = '{rdni_pkg::ALU_MUL, R_YD, R_Y,  R_T};
            E_J3:   uop = '{rdni_pkg::ALU_ADD, R_C,  R_T,  R_J3};
            N_DX:   uop = '{rdni_pkg::ALU_SUB, R_FX, R_PX, R_DX};
            N_DY:   uop = '{rdni_pkg::ALU_SUB, R_FY, R_PY, R_DY};
            N_A:    uop = '{rdni_pkg::ALU_MUL, R_J0, R_J3, R_T};
            N_B:    uop = '{rdni_pkg::ALU_MUL, R_J1, R_J2, R_U};
            N_DET:  uop = '{rdni_pkg::ALU_SUB, R_T,  R_U,  R_DET};
            N_C:    uop = '{rdni_pkg::ALU_MUL, R_J3, R_DX, R_T};
            N_D:    uop = '{rdni_pkg::ALU_MUL, R_J1, R_DY, R_U};
            N_NX:   uop = '{rdni_pkg::ALU_SUB, R_T,  R_U,  R_NX};
            N_E:    uop = '{rdni_pkg::ALU_MUL, R_J0, R_DY, R_T};
            N_F:    uop = '{rdni_pkg::ALU_MUL, R_J2, R_DX, R_U};
            N_NY:   uop = '{rdni_pkg::ALU_SUB, R_T,  R_U,  R_NY};
            N_QX:   uop = '{rdni_pkg::ALU_DIV, R_NX, R_DET, R_T};
            N_SX:   uop = '{rdni_pkg::ALU_SUB, R_X,  R_T,  R_T};
            N_CX:   uop = '{rdni_pkg::ALU_CLAMP, R_T, R_T, R_X};
            N_QY:   uop = '{rdni_pkg::ALU_DIV, R_NY, R_DET, R_T};
            N_SY:   uop = '{rdni_pkg::ALU_SUB, R_Y,  R_T,  R_T};
            N_CY:   uop = '{rdni_pkg::ALU_CLAMP, R_T, R_T, R_Y};
            F_C0:   uop = '{rdni_pkg::ALU_CLAMP, R_J0, R_J0, R_J0};
            F_C1:   uop = '{rdni_pkg::ALU_CLAMP, R_J1, R_J1, R_J1};
            F_C2:   uop = '{rdni_pkg::ALU_CLAMP, R_J2, R_J2, R_J2};
            F_C3:   uop = '{rdni_pkg::ALU_CLAMP, R_J3, R_J3, R_J3};
            F_CX:   uop = '{rdni_pkg::ALU_CLAMP, R_FX, R_FX, R_X};
            F_CY:   uop = '{rdni_pkg::ALU_CLAMP, R_FY, R_FY, R_Y};
            default: is_alu = 1'b0;
        endcase
    end

    assign alu_a       = rf_reg[uop.a];
    assign alu_b       = rf_reg[uop.b];
    assign alu_ctl.op  = uop.op;
    assign alu_ctl.start = is_alu && !issued_reg;

    // convergence: both residuals below 2^16 and squared norm within tolerance
    always_comb
    begin
        adx  = rf_reg[R_DX][63] ? (64'd0 - rf_reg[R_DX]) : rf_reg[R_DX];
        ady  = rf_reg[R_DY][63] ? (64'd0 - rf_reg[R_DY]) : rf_reg[R_DY];
        norm = 33'({16'd0, adx[15:0]} * {16'd0, adx[15:0]})
             + 33'({16'd0, ady[15:0]} * {16'd0, ady[15:0]});
        conv = (adx[63:16] == '0) && (ady[63:16] == '0) && (norm <= 33'(tol_reg));
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= P_IDLE;
            issued_reg   <= 1'b0;
            done_reg     <= 1'b0;
            k1_reg       <= '0;
            k2_reg       <= '0;
            k3_reg       <= '0;
            tol_reg      <= '0;
            limit_reg    <= rdni_pkg::LIMIT_RESET;
            sat_acc_reg  <= 1'b0;
            singular_reg <= 1'b0;
            limited_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    rdni_pkg::REG_K1:    k1_reg    <= cfg_data;
                    rdni_pkg::REG_K2:    k2_reg    <= cfg_data;
                    rdni_pkg::REG_K3:    k3_reg    <= cfg_data;
                    rdni_pkg::REG_TOL:   tol_reg   <= cfg_data[15:0];
                    rdni_pkg::REG_LIMIT: limit_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (is_alu)
            begin
                // wait on the shared unit, then write back and move on
                if (!issued_reg)
                    issued_reg <= 1'b1;
                else if (alu_sts.done)
                begin
                    issued_reg       <= 1'b0;
                    rf_reg[uop.dst]  <= alu_y;
                    sat_acc_reg      <= sat_acc_reg | alu_sts.sat;
                    case (step_reg)
                        E_FY:   step_reg <= E_ZCHK;
                        E_J3:   step_reg <= E_RET;
                        N_DY:   step_reg <= N_CONV;
                        N_DET:  step_reg <= N_DCHK;
                        N_CY:   step_reg <= N_CNT;
                        F_CY:   step_reg <= P_OUT;
                        E_D1:   step_reg <= E_KR2;
                        E_KR2:  step_reg <= E_D2;
                        E_D2:   step_reg <= E_D3;
                        E_D5:   step_reg <= E_KR4;
                        E_KR4:  step_reg <= E_D6;
                        E_D6:   step_reg <= E_D7;
                        E_D11:  step_reg <= E_XD;
                        default: step_reg <= step_t'(step_reg + 7'd1);
                    endcase
                end
            end
            else
            begin
                case (step_reg)
                    P_IDLE:
                    begin
                        // the strobe cycle still counts as busy
                        if (start && !done_reg)
                        begin
                            inv_reg      <= op;
                            rf_reg[R_X]  <= 64'(in_x);
                            rf_reg[R_Y]  <= 64'(in_y);
                            rf_reg[R_PX] <= 64'(in_x);
                            rf_reg[R_PY] <= 64'(in_y);
                            rf_reg[R_K1] <= 64'(k1_reg);
                            rf_reg[R_K2] <= 64'(k2_reg);
                            rf_reg[R_K3] <= 64'(k3_reg);
                            rf_reg[R_ONE] <= ONE;
                            sat_acc_reg  <= 1'b0;
                            singular_reg <= 1'b0;
                            limited_reg  <= 1'b0;
                            count_reg    <= '0;
                            step_reg     <= E_XX;
                        end
                    end
                    E_ZCHK:
                    begin
                        if (rf_reg[R_R2] == '0)
                        begin
                            rf_reg[R_J0] <= ONE;
                            rf_reg[R_J1] <= '0;
                            rf_reg[R_J2] <= '0;
                            rf_reg[R_J3] <= ONE;
                            step_reg     <= E_RET;
                        end
                        else
                            step_reg <= E_D1;
                    end
                    E_RET:
                        step_reg <= inv_reg ? N_DX : F_C0;
                    N_CONV:
                    begin
                        if (count_reg != '0 && count_reg > {1'b0, limit_reg})
                        begin
                            limited_reg <= !conv;
                            step_reg    <= P_OUT;
                        end
                        else if (conv)
                            step_reg <= P_OUT;
                        else
                            step_reg <= N_A;
                    end
                    N_DCHK:
                    begin
                        if (rf_reg[R_DET] == '0)
                        begin
                            singular_reg <= 1'b1;
                            step_reg     <= P_OUT;
                        end
                        else
                            step_reg <= N_C;
                    end
                    N_CNT:
                    begin
                        count_reg <= count_reg + 9'd1;
                        step_reg  <= E_XX;
                    end
                    P_OUT:
                    begin
                        done_reg <= 1'b1;
                        status_reg <= singular_reg ? rdni_pkg::ST_SINGULAR
                                    : sat_acc_reg  ? rdni_pkg::ST_SAT
                                    : limited_reg  ? rdni_pkg::ST_LIMIT
                                    : rdni_pkg::ST_OK;
                        step_reg <= P_IDLE;
                    end
                    default: step_reg <= P_IDLE;
                endcase
            end
        end
    end

    // outputs are the working registers (jac_* zero in inverse mode), shown with the done strobe
    assign busy         = (step_reg != P_IDLE) || done_reg;
    assign done         = done_reg;
    assign out_x        = rf_reg[R_X][COORD_WIDTH-1:0];
    assign out_y        = rf_reg[R_Y][COORD_WIDTH-1:0];
    assign jac_xx       = inv_reg ? '0 : rf_reg[R_J0][COORD_WIDTH-1:0];
    assign jac_xy       = inv_reg ? '0 : rf_reg[R_J1][COORD_WIDTH-1:0];
    assign jac_yx       = inv_reg ? '0 : rf_reg[R_J2][COORD_WIDTH-1:0];
    assign jac_yy       = inv_reg ? '0 : rf_reg[R_J3][COORD_WIDTH-1:0];
    assign update_count = count_reg;
    assign status       = status_reg;
endmodule

// ----- hw/rtl/rdni_checker.sv -----
`timescale 1ns / 1ps
`include "radial_distortion_newton_inverse_defines.svh"
module rdni_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [8:0] update_count,
    input logic [1:0] status
);
    `RDNI_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised")
    `RDNI_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done held two cycles")
    `RDNI_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy, "result outside transaction")
    `RDNI_ASSERT_IMPL(a_fwd_status, clk, rst_n, done && update_count == 9'd0 && status == rdni_pkg::ST_LIMIT, 1'b0, "limit status without updates")
endmodule

bind radial_distortion_newton_inverse rdni_checker u_rdni_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .update_count (update_count),
    .status       (status)
);
